FILE: hw/rtl/shcd_pkg.sv
package shcd_pkg;

  localparam int COORD_BITS = 24;
  localparam int ID_BITS = 32;
  localparam int IDENT_BITS = 14;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = (COORD_BITS > IDENT_BITS) ? COORD_BITS : IDENT_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IDENTITY_CUTOFF = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH_CUTOFF = CFG_INDEX_BITS'(1);

  localparam logic [IDENT_BITS-1:0] IDENTITY_CUTOFF_RESET = IDENT_BITS'(5000);
  localparam logic [COORD_BITS-1:0] LENGTH_CUTOFF_RESET = COORD_BITS'(100);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Separation test: 5 * overlap < min(LIM_CAP, shorter length)
  localparam int LIM_CAP = 300;
  localparam int LIM_BITS = $clog2(LIM_CAP + 1);
  localparam int OV_BITS = COORD_BITS + 3;
  localparam int OV5_BITS = OV_BITS + 3;

  localparam logic KIND_SELF = 1'b0;
  localparam logic KIND_MULTI = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ID_BITS-1:0] id_t;

  // Classified record handed from the front to the back.
  typedef struct packed {
    logic   flush;
    logic   first;
    logic   same_q;
    logic   same_h;
    logic   minus;
    logic   asc;
    logic   desc;
    coord_t qstart;
    coord_t qend;
    id_t    prev_query;
  } entry_t;

  // Plus (a) and minus (b) ranges of a closed group.
  typedef struct packed {
    logic   ok;
    coord_t s_a;
    coord_t e_a;
    coord_t s_b;
    coord_t e_b;
  } pair_t;

  typedef struct packed {
    logic   pass;
    logic   a_longer;
    coord_t lo_a;
    coord_t hi_a;
    coord_t lo_b;
    coord_t hi_b;
  } verdict_t;

  typedef struct packed {
    logic   kind;
    id_t    query;
    coord_t lo;
    coord_t hi;
    logic   last;
  } result_t;

endpackage

FILE: hw/rtl/shcd_front.sv
module shcd_front import shcd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [ID_BITS-1:0]        query_id,
  input  logic [ID_BITS-1:0]        hit_id,
  input  logic [COORD_BITS-1:0]     query_start,
  input  logic [COORD_BITS-1:0]     query_end,
  input  logic                      minus_strand,
  input  logic [IDENT_BITS-1:0]     identity,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output logic                      push,
  output entry_t                    push_entry,
  input  logic                      queue_full
);

  logic [IDENT_BITS-1:0] identity_cutoff;
  logic [COORD_BITS-1:0] min_span;
  logic                  have_prev;
  id_t                   prev_q;
  id_t                   prev_h;

  logic                  accept;
  logic                  asc;
  logic                  desc;
  coord_t                span_m1;
  logic                  long_enough;
  logic                  keep;

  assign cfg_ready = 1'b1;
  assign in_stall = queue_full;
  assign accept = in_valid && !queue_full;

  always_comb begin
    asc = query_start < query_end;
    desc = query_start > query_end;
    span_m1 = desc ? (query_start - query_end) : (query_end - query_start);
    long_enough = ((COORD_BITS+1)'(span_m1) + (COORD_BITS+1)'(1)) >=
                  (COORD_BITS+1)'(min_span);
    keep = action || ((identity >= identity_cutoff) && long_enough);
  end

  assign push = accept && keep;

  always_comb begin
    push_entry.flush = action;
    push_entry.first = !have_prev;
    push_entry.same_q = !action && have_prev && (query_id == prev_q);
    push_entry.same_h = !action && have_prev && (hit_id == prev_h);
    push_entry.minus = minus_strand;
    push_entry.asc = asc;
    push_entry.desc = desc;
    push_entry.qstart = query_start;
    push_entry.qend = query_end;
    push_entry.prev_query = prev_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      identity_cutoff <= IDENTITY_CUTOFF_RESET;
      min_span <= LENGTH_CUTOFF_RESET;
      have_prev <= 1'b0;
      prev_q <= '0;
      prev_h <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IDENTITY_CUTOFF: identity_cutoff <= cfg_data[IDENT_BITS-1:0];
          REG_LENGTH_CUTOFF:   min_span <= cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (push) begin
        if (action) begin
          have_prev <= 1'b0;
          prev_q <= '0;
          prev_h <= '0;
        end else begin
          have_prev <= 1'b1;
          prev_q <= query_id;
          prev_h <= hit_id;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/shcd_queue.sv
module shcd_queue import shcd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;

  assign full = count == QCNT_BITS'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head = slots[rd_ptr];

  function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop && head_valid) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push && !full, pop && head_valid})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/shcd_check.sv
module shcd_check import shcd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  pair_t    pair,
  output verdict_t verdict
);

  // stage 1: order each range, take its length minus one
  logic                  c1_ok;
  coord_t                c1_lo_a, c1_hi_a, c1_d_a;
  coord_t                c1_lo_b, c1_hi_b, c1_d_b;
  // stage 2: combined bounds, sum and minimum of lengths minus one
  logic                  c2_ok;
  logic                  c2_a_longer;
  coord_t                c2_lo, c2_hi, c2_dmin;
  logic [COORD_BITS:0]   c2_dsum;
  coord_t                c2_lo_a, c2_hi_a, c2_lo_b, c2_hi_b;
  // stage 3: overlap and limit
  logic                  c3_ok;
  logic                  c3_a_longer;
  logic [OV_BITS-1:0]    c3_ov;
  logic [LIM_BITS-1:0]   c3_lim;
  coord_t                c3_lo_a, c3_hi_a, c3_lo_b, c3_hi_b;

  logic                  a_asc, b_asc;
  coord_t                span;
  logic [OV_BITS-1:0]    ov_next;
  logic [LIM_BITS-1:0]   lim_next;
  logic signed [OV5_BITS-1:0] ov_ext, ov5, lim_s;

  assign a_asc = pair.s_a < pair.e_a;
  assign b_asc = pair.s_b < pair.e_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_ok <= 1'b0;
      c2_ok <= 1'b0;
      c3_ok <= 1'b0;
    end else if (adv) begin
      c1_ok <= pair.ok;
      c2_ok <= c1_ok;
      c3_ok <= c2_ok;
    end
  end

  always_comb begin
    span = c2_hi - c2_lo;
    ov_next = OV_BITS'(c2_dsum) + OV_BITS'(3) - OV_BITS'(span);
    if (OV_BITS'(c2_dmin) < OV_BITS'(LIM_CAP)) begin
      lim_next = LIM_BITS'(c2_dmin) + LIM_BITS'(1);
    end else begin
      lim_next = LIM_BITS'(LIM_CAP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_lo_a <= a_asc ? pair.s_a : pair.e_a;
      c1_hi_a <= a_asc ? pair.e_a : pair.s_a;
      c1_d_a <= a_asc ? (pair.e_a - pair.s_a) : (pair.s_a - pair.e_a);
      c1_lo_b <= b_asc ? pair.s_b : pair.e_b;
      c1_hi_b <= b_asc ? pair.e_b : pair.s_b;
      c1_d_b <= b_asc ? (pair.e_b - pair.s_b) : (pair.s_b - pair.e_b);

      c2_lo <= (c1_lo_a < c1_lo_b) ? c1_lo_a : c1_lo_b;
      c2_hi <= (c1_hi_a > c1_hi_b) ? c1_hi_a : c1_hi_b;
      c2_dsum <= (COORD_BITS+1)'(c1_d_a) + (COORD_BITS+1)'(c1_d_b);
      c2_dmin <= (c1_d_a < c1_d_b) ? c1_d_a : c1_d_b;
      c2_a_longer <= c1_d_a > c1_d_b;
      c2_lo_a <= c1_lo_a;
      c2_hi_a <= c1_hi_a;
      c2_lo_b <= c1_lo_b;
      c2_hi_b <= c1_hi_b;

      c3_ov <= ov_next;
      c3_lim <= lim_next;
      c3_a_longer <= c2_a_longer;
      c3_lo_a <= c2_lo_a;
      c3_hi_a <= c2_hi_a;
      c3_lo_b <= c2_lo_b;
      c3_hi_b <= c2_hi_b;
    end
  end

  // 5 * overlap as shift and add, compared signed against the limit
  always_comb begin
    ov_ext = OV5_BITS'($signed(c3_ov));
    ov5 = (ov_ext <<< 2) + ov_ext;
    lim_s = OV5_BITS'(c3_lim);
    verdict.pass = c3_ok && (ov5 < lim_s);
    verdict.a_longer = c3_a_longer;
    verdict.lo_a = c3_lo_a;
    verdict.hi_a = c3_hi_a;
    verdict.lo_b = c3_lo_b;
    verdict.hi_b = c3_hi_b;
  end

endmodule

FILE: hw/rtl/shcd_back.sv
module shcd_back import shcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  entry_t                head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  report_kind,
  output logic [ID_BITS-1:0]    reported_query,
  output logic [COORD_BITS-1:0] range_low,
  output logic [COORD_BITS-1:0] range_high,
  output logic                  last_of_run
);

  localparam int SLOT_HIT_PLUS = 0;
  localparam int SLOT_HIT_MINUS = 1;
  localparam int SLOT_QRY_PLUS = 2;
  localparam int SLOT_QRY_MINUS = 3;
  localparam int NUM_SLOTS = 4;
  localparam int SB_DEPTH = 4;

  localparam logic [1:0] GRP_START = 2'd0;
  localparam logic [1:0] GRP_MERGE = 2'd1;
  localparam logic [1:0] GRP_CLEAR = 2'd2;

  typedef struct packed {
    logic   valid;
    coord_t s;
    coord_t e;
  } slot_t;

  slot_t      slot [NUM_SLOTS];
  slot_t      slot_next [NUM_SLOTS];
  logic [1:0] hit_act;
  logic [1:0] qry_act;
  logic       hit_chk;
  logic       qry_chk;

  pair_t      pair_hit;
  pair_t      pair_qry;
  verdict_t   vd_hit;
  verdict_t   vd_qry;

  logic       sb_valid [SB_DEPTH];
  logic       sb_reset [SB_DEPTH];
  id_t        sb_query [SB_DEPTH];

  logic       clean;
  logic       adv;
  logic       out_free;
  logic       hit_rep;
  logic       qry_rep;
  result_t    r_self, r_m0, r_m1;
  result_t    out_res;
  result_t    pend_res;
  logic       pend_valid;

  function automatic slot_t merge_slot(input slot_t cur, input entry_t ent);
    slot_t r;
    r = cur;
    if (!cur.valid) begin
      r.valid = 1'b1;
      r.s = ent.qstart;
      r.e = ent.qend;
    end else if ((cur.s < cur.e) && ent.asc) begin
      r.s = (cur.s < ent.qstart) ? cur.s : ent.qstart;
      r.e = (cur.e < ent.qend) ? ent.qend : cur.e;
    end else if ((cur.s > cur.e) && ent.desc) begin
      r.s = (cur.s > ent.qstart) ? cur.s : ent.qstart;
      r.e = (cur.e > ent.qend) ? ent.qend : cur.e;
    end
    return r;
  endfunction

  function automatic slot_t group_next(input slot_t cur, input logic is_minus,
                                       input logic [1:0] act, input entry_t ent);
    slot_t r;
    r = cur;
    case (act)
      GRP_CLEAR: r.valid = 1'b0;
      GRP_START: begin
        if (ent.minus == is_minus) begin
          r.valid = 1'b1;
          r.s = ent.qstart;
          r.e = ent.qend;
        end else begin
          r.valid = 1'b0;
        end
      end
      GRP_MERGE: begin
        if (ent.minus == is_minus) begin
          r = merge_slot(cur, ent);
        end
      end
      default: r = cur;
    endcase
    return r;
  endfunction

  // Whole back pipeline moves in lockstep; it halts only while results back up.
  assign out_free = !out_valid || !out_stall;
  assign adv = out_free && !pend_valid;
  assign pop = head_valid && adv;

  always_comb begin
    if (head.flush) begin
      hit_act = GRP_CLEAR;
      qry_act = GRP_CLEAR;
    end else begin
      hit_act = (head.first || !(head.same_q && head.same_h)) ? GRP_START : GRP_MERGE;
      qry_act = (head.first || !head.same_q) ? GRP_START : GRP_MERGE;
    end
    hit_chk = head_valid && !head.first && !(head.same_q && head.same_h);
    qry_chk = head_valid && !head.first && !head.same_q;
    slot_next[SLOT_HIT_PLUS] = group_next(slot[SLOT_HIT_PLUS], 1'b0, hit_act, head);
    slot_next[SLOT_HIT_MINUS] = group_next(slot[SLOT_HIT_MINUS], 1'b1, hit_act, head);
    slot_next[SLOT_QRY_PLUS] = group_next(slot[SLOT_QRY_PLUS], 1'b0, qry_act, head);
    slot_next[SLOT_QRY_MINUS] = group_next(slot[SLOT_QRY_MINUS], 1'b1, qry_act, head);
  end

  // Merge state and snapshot of the groups being closed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot[i].valid <= 1'b0;
      end
      for (int i = 0; i < SB_DEPTH; i++) begin
        sb_valid[i] <= 1'b0;
      end
    end else if (adv) begin
      if (pop) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          slot[i] <= slot_next[i];
        end
      end
      sb_valid[0] <= head_valid;
      for (int i = 1; i < SB_DEPTH; i++) begin
        sb_valid[i] <= sb_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair_hit.ok <= hit_chk && slot[SLOT_HIT_PLUS].valid && slot[SLOT_HIT_MINUS].valid;
      pair_hit.s_a <= slot[SLOT_HIT_PLUS].s;
      pair_hit.e_a <= slot[SLOT_HIT_PLUS].e;
      pair_hit.s_b <= slot[SLOT_HIT_MINUS].s;
      pair_hit.e_b <= slot[SLOT_HIT_MINUS].e;
      pair_qry.ok <= qry_chk && slot[SLOT_QRY_PLUS].valid && slot[SLOT_QRY_MINUS].valid;
      pair_qry.s_a <= slot[SLOT_QRY_PLUS].s;
      pair_qry.e_a <= slot[SLOT_QRY_PLUS].e;
      pair_qry.s_b <= slot[SLOT_QRY_MINUS].s;
      pair_qry.e_b <= slot[SLOT_QRY_MINUS].e;
      sb_reset[0] <= !head.same_q;
      sb_query[0] <= head.prev_query;
      for (int i = 1; i < SB_DEPTH; i++) begin
        sb_reset[i] <= sb_reset[i-1];
        sb_query[i] <= sb_query[i-1];
      end
    end
  end

  shcd_check u_check_hit (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .pair    (pair_hit),
    .verdict (vd_hit)
  );

  shcd_check u_check_qry (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .pair    (pair_qry),
    .verdict (vd_qry)
  );

  // Resolve reports in order against the running clean flag.
  always_comb begin
    hit_rep = sb_valid[SB_DEPTH-1] && clean && vd_hit.pass;
    qry_rep = sb_valid[SB_DEPTH-1] && clean && !vd_hit.pass && vd_qry.pass;

    r_self.kind = KIND_SELF;
    r_self.query = sb_query[SB_DEPTH-1];
    r_self.lo = vd_hit.a_longer ? vd_hit.lo_a : vd_hit.lo_b;
    r_self.hi = vd_hit.a_longer ? vd_hit.hi_a : vd_hit.hi_b;
    r_self.last = 1'b1;

    r_m0.kind = KIND_MULTI;
    r_m0.query = sb_query[SB_DEPTH-1];
    r_m0.lo = vd_qry.lo_a;
    r_m0.hi = vd_qry.hi_a;
    r_m0.last = 1'b0;

    r_m1.kind = KIND_MULTI;
    r_m1.query = sb_query[SB_DEPTH-1];
    r_m1.lo = vd_qry.lo_b;
    r_m1.hi = vd_qry.hi_b;
    r_m1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clean <= 1'b1;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (adv) begin
      if (sb_valid[SB_DEPTH-1]) begin
        clean <= sb_reset[SB_DEPTH-1] ? 1'b1 : (clean && !(hit_rep || qry_rep));
      end
      if (hit_rep) begin
        out_valid <= 1'b1;
        out_res <= r_self;
      end else if (qry_rep) begin
        out_valid <= 1'b1;
        out_res <= r_m0;
        pend_valid <= 1'b1;
        pend_res <= r_m1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= pend_valid;
      out_res <= pend_res;
      pend_valid <= 1'b0;
    end
  end

  assign report_kind = out_res.kind;
  assign reported_query = out_res.query;
  assign range_low = out_res.lo;
  assign range_high = out_res.hi;
  assign last_of_run = out_res.last;

`ifndef ASSERT_OFF
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second result queued with no first result shown");

  a_partner_queued: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.last) |-> pend_valid)
    else $error("non-final result shown without its partner queued");

  a_report_dirties: assert property (@(posedge clk) disable iff (rst)
    (adv && sb_valid[SB_DEPTH-1] && (hit_rep || qry_rep) && !sb_reset[SB_DEPTH-1])
      |=> !clean)
    else $error("query still marked clean after a report");
`endif

endmodule

FILE: hw/rtl/strand_hit_chimera_detector.sv
// A kept record or flush passes the queue, snapshot registers, check stages and out register.
// Throughput: one item per cycle while the output is not stalled; an item that yields a
//   trans-multi report holds the back end while its second result waits behind the first.
// Reset (rst, synchronous): empties the queue and pipeline, clears the merged ranges and
//   the previous-record tracking, marks the query clean, loads identity_cutoff 5000 and
//   min_span 100.
module strand_hit_chimera_detector import shcd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // record channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [ID_BITS-1:0]        query_id,
  input  logic [ID_BITS-1:0]        hit_id,
  input  logic [COORD_BITS-1:0]     query_start,
  input  logic [COORD_BITS-1:0]     query_end,
  input  logic                      minus_strand,
  input  logic [IDENT_BITS-1:0]     identity,
  // report channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      report_kind,
  output logic [ID_BITS-1:0]        reported_query,
  output logic [COORD_BITS-1:0]     range_low,
  output logic [COORD_BITS-1:0]     range_high,
  output logic                      last_of_run,
  // register write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Front: filter records against the cutoffs, compare ids with the last kept record,
  // and push a classified entry. Filtered records are dropped here and never reach
  // the back. The front stalls the input only when the queue is full.
  logic   push;
  entry_t push_entry;
  logic   queue_full;

  // Back: pop entries, update the four merged ranges, and run the closed groups
  // through the separation pipeline. A transfer on the output is what drains it.
  logic   pop;
  logic   head_valid;
  entry_t head;

  shcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .query_id     (query_id),
    .hit_id       (hit_id),
    .query_start  (query_start),
    .query_end    (query_end),
    .minus_strand (minus_strand),
    .identity     (identity),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_entry   (push_entry),
    .queue_full   (queue_full)
  );

  // Short queue decouples the two halves so an output stall does not reach the input
  // until it is full.
  shcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  shcd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .report_kind    (report_kind),
    .reported_query (reported_query),
    .range_low      (range_low),
    .range_high     (range_high),
    .last_of_run    (last_of_run)
  );

endmodule
